>>> rtl/interval_profiling_counters_assert.svh
// Assertion macros shared by the interval profiling counter RTL.
// Expects a clock named clk and a synchronous active-high reset named rst.
`ifndef INTERVAL_PROFILING_COUNTERS_ASSERT_SVH
`define INTERVAL_PROFILING_COUNTERS_ASSERT_SVH

// same-cycle implication
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ipc_pkg.sv
// Package for the interval profiling counters: field widths, codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package ipc_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 8;
  localparam int TIME_W    = 32;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 32;
  localparam int FUNC_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_STAMP = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WRITE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic load_item;
    logic mem_read;
    logic write_start;
    logic calc_diff;
    logic write_stamp;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              div_done;
    logic              out_full;
  } sts_t;

endpackage

>>> rtl/interval_profiling_counters.sv
// Top level of the interval profiling counters.
// Depends on ipc_pkg, ipc_ctrl and ipc_datapath.
//
// Usage:
//   Input stream s_*: s_tuser = func (0 start, 1 stamp, 2 query), s_tdata holds
//   slot, next_slot and cycle_now. Starts and stamps give no result; a query
//   gives one transfer on m_* with the slot's sum, count and average.
//   s_tready is high only while the controller is idle; one item at a time.
//   Steps per item: start reads and writes the start time; stamp reads,
//   takes the difference and writes back; a query reads and then runs the
//   bit-serial divider, producing one quotient bit per cycle, unless the slot
//   is out of range, the count is zero or the average saturates, in which
//   case the divider gives its result without iterating.
//   The result sits in an output register until m_tready takes it; a stalled
//   receiver blocks only the next query, which waits in the divide state.
//   Reset (rst, synchronous) clears the per-slot valid bits at once, so all
//   slots read as zero; no clearing pass is needed and items are accepted as
//   soon as reset is released.
module interval_profiling_counters
  import ipc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [7:0] slot, [15:8] next_slot, [47:16] cycle_now
  input  logic [2*SLOT_W+TIME_W-1:0] s_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]          s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [63:0] interval_sum, [95:64] event_count, [127:96] average_cycles
  output logic [SUM_W+2*CNT_W-1:0]   m_tdata,
  // [0] slot_valid
  output logic [0:0]                 m_tuser
);

  cmd_t cmd;
  sts_t sts;

  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/ipc_ctrl.sv
// Controller state machine of the interval profiling counters.
// Depends on ipc_pkg; drives the datapath through cmd_t, observes sts_t.
module ipc_ctrl
  import ipc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.func)
          FUNC_STAMP: state_next = ST_WRITE;
          FUNC_QUERY: state_next = ST_DIV;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (sts.div_done && !sts.out_full) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
      end
      ST_EXEC: begin
        case (sts.func)
          FUNC_START: cmd.write_start = 1'b1;
          FUNC_STAMP: cmd.calc_diff   = 1'b1;
          FUNC_QUERY: cmd.div_start   = 1'b1;
          default:    ;
        endcase
      end
      ST_WRITE: begin
        cmd.write_stamp = 1'b1;
      end
      ST_DIV: begin
        cmd.load_out = sts.div_done && !sts.out_full;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ipc_div.sv
// Iterative 64/32 unsigned divider, one quotient bit per cycle, 32-bit saturated.
// Depends on ipc_pkg; used by the datapath for the average.
module ipc_div
  import ipc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [CNT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    shifted;
  logic              take;

  assign shifted = {rem, quotient[CNT_W-1]};
  assign take    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      if (divisor == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (dividend[SUM_W-1:CNT_W] >= divisor) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        busy  <= 1'b1;
        done  <= 1'b0;
        steps <= STEP_W'(CNT_W);
      end
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[SUM_W-1:CNT_W];
      if (divisor == '0) begin
        quotient <= '0;
      end else if (dividend[SUM_W-1:CNT_W] >= divisor) begin
        quotient <= '1;
      end else begin
        quotient <= dividend[CNT_W-1:0];
      end
    end else if (busy) begin
      rem      <= take ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
      quotient <= {quotient[CNT_W-2:0], take};
    end
  end

endmodule

>>> rtl/ipc_datapath.sv
// Datapath of the interval profiling counters: item register, slot memories with
// per-slot valid bits, interval adder, divider and output register.
// Depends on ipc_pkg, ipc_div and interval_profiling_counters_assert.svh.
`include "interval_profiling_counters_assert.svh"

module ipc_datapath
  import ipc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2*SLOT_W+TIME_W-1:0]  s_tdata,
  input  logic [FUNC_W-1:0]           s_tuser,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [SUM_W+2*CNT_W-1:0]    m_tdata,
  output logic [0:0]                  m_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(SLOTS);

  logic [FUNC_W-1:0] item_func;
  logic [SLOT_W-1:0] item_slot;
  logic [SLOT_W-1:0] item_next;
  logic [TIME_W-1:0] item_now;
  logic              slot_ok;
  logic              next_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  next_idx;

  logic [TIME_W-1:0] start_mem [SLOTS];
  logic [SUM_W-1:0]  sum_mem   [SLOTS];
  logic [CNT_W-1:0]  cnt_mem   [SLOTS];
  logic [SLOTS-1:0]  start_vld;
  logic [SLOTS-1:0]  acc_vld;

  logic [TIME_W-1:0] rd_start;
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_svld;
  logic              rd_avld;

  logic [TIME_W-1:0] start_eff;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  acc_cnt;
  logic [TIME_W-1:0] diff;

  logic              start_we;
  logic [IDX_W-1:0]  start_addr;
  logic              acc_we;

  logic              div_busy;
  logic              div_done;
  logic [CNT_W-1:0]  div_quo;

  logic              out_valid;
  logic              out_slot_valid;
  logic [SUM_W-1:0]  out_sum;
  logic [CNT_W-1:0]  out_cnt;
  logic [CNT_W-1:0]  out_avg;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func <= s_tuser;
      item_slot <= s_tdata[SLOT_W-1:0];
      item_next <= s_tdata[2*SLOT_W-1:SLOT_W];
      item_now  <= s_tdata[2*SLOT_W+TIME_W-1:2*SLOT_W];
    end
  end

  assign slot_ok  = {1'b0, item_slot} < SLOT_LIM;
  assign next_ok  = {1'b0, item_next} < SLOT_LIM;
  assign slot_idx = item_slot[IDX_W-1:0];
  assign next_idx = item_next[IDX_W-1:0];

  // registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_start <= start_mem[slot_idx];
      rd_sum   <= sum_mem[slot_idx];
      rd_cnt   <= cnt_mem[slot_idx];
      rd_svld  <= start_vld[slot_idx];
      rd_avld  <= acc_vld[slot_idx];
    end
  end

  assign start_eff = rd_svld ? rd_start : '0;
  assign acc_sum   = (slot_ok && rd_avld) ? rd_sum : '0;
  assign acc_cnt   = (slot_ok && rd_avld) ? rd_cnt : '0;

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      diff <= item_now - start_eff;
    end
  end

  assign start_we   = slot_ok && (cmd.write_start || (cmd.write_stamp && next_ok));
  assign start_addr = cmd.write_stamp ? next_idx : slot_idx;
  assign acc_we     = slot_ok && cmd.write_stamp;

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_addr] <= item_now;
    end
    if (acc_we) begin
      sum_mem[slot_idx] <= acc_sum + {{(SUM_W-TIME_W){1'b0}}, diff};
      cnt_mem[slot_idx] <= acc_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vld <= '0;
      acc_vld   <= '0;
    end else begin
      if (start_we) begin
        start_vld[start_addr] <= 1'b1;
      end
      if (acc_we) begin
        acc_vld[slot_idx] <= 1'b1;
      end
    end
  end

  ipc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc_sum),
    .divisor  (acc_cnt),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slot_valid <= slot_ok;
      out_sum        <= acc_sum;
      out_cnt        <= acc_cnt;
      out_avg        <= div_quo;
    end
  end

  assign sts.func     = item_func;
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_avg, out_cnt, out_sum};
  assign m_tuser  = out_slot_valid;

  `IPC_ASSERT_NOW(a_load_needs_room, cmd.load_out, div_done && !out_valid, "result loaded over a pending one")
  `IPC_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid, "loaded result not presented")
  `IPC_ASSERT_NOW(a_div_exclusive, div_done, !div_busy, "divider done while still busy")
  `IPC_ASSERT_NOW(a_one_write_src, cmd.write_start, !cmd.write_stamp, "two start writes in one cycle")

endmodule

>>> verif/tb_interval_profiling_counters.sv
// Self-checking testbench for interval_profiling_counters: start, stamp and query
// transfers with random gaps and stalls, checked against an internal slot model.
// Depends on ipc_pkg and the interval_profiling_counters RTL.
module tb_interval_profiling_counters;
  timeunit 1ns;
  timeprecision 1ps;
  import ipc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] avg;
  } slot_stats_t;

  class slot_profile_board;
    logic [TIME_W-1:0] start_at    [SLOTS_DEF];
    logic [SUM_W-1:0]  cycle_total [SLOTS_DEF];
    logic [CNT_W-1:0]  stamp_count [SLOTS_DEF];
    slot_stats_t       expected_stats [$];
    int                mismatches;
    int                checked;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        start_at[i]    = '0;
        cycle_total[i] = '0;
        stamp_count[i] = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_item(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] sl,
                            logic [SLOT_W-1:0] nx, logic [TIME_W-1:0] now);
      slot_stats_t      st;
      logic [SUM_W-1:0] quot;
      st = '0;
      case (f)
        FUNC_START: begin
          if (sl < SLOTS_DEF) start_at[sl] = now;
        end
        FUNC_STAMP: begin
          if (sl < SLOTS_DEF) begin
            cycle_total[sl] = cycle_total[sl] + {32'd0, now - start_at[sl]};
            stamp_count[sl] = stamp_count[sl] + 1;
            if (nx < SLOTS_DEF) start_at[nx] = now;
          end
        end
        FUNC_QUERY: begin
          if (sl < SLOTS_DEF) begin
            st.valid = 1'b1;
            st.sum   = cycle_total[sl];
            st.count = stamp_count[sl];
            if (stamp_count[sl] != 0) begin
              quot   = cycle_total[sl] / {32'd0, stamp_count[sl]};
              st.avg = (quot > 64'hFFFF_FFFF) ? '1 : quot[CNT_W-1:0];
            end
          end
          expected_stats.push_back(st);
        end
        default: ;
      endcase
    endfunction

    function void check_stats(logic v, logic [SUM_W-1:0] sum, logic [CNT_W-1:0] cnt,
                              logic [CNT_W-1:0] avg);
      slot_stats_t want;
      if (expected_stats.size() == 0) begin
        $error("result transfer with no query pending");
        mismatches++;
        return;
      end
      want = expected_stats.pop_front();
      checked++;
      if (v !== want.valid) begin
        $error("slot_valid: expected %0d, got %0d", want.valid, v);
        mismatches++;
      end
      if (sum !== want.sum) begin
        $error("interval_sum: expected %0h, got %0h", want.sum, sum);
        mismatches++;
      end
      if (cnt !== want.count) begin
        $error("event_count: expected %0h, got %0h", want.count, cnt);
        mismatches++;
      end
      if (avg !== want.avg) begin
        $error("average_cycles: expected %0h, got %0h", want.avg, avg);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [2*SLOT_W+TIME_W-1:0] s_tdata;
  logic [FUNC_W-1:0]          s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [SUM_W+2*CNT_W-1:0]   m_tdata;
  logic [0:0]                 m_tuser;

  slot_profile_board sb;
  int  burst_left;
  int  func_seen [4];
  bit  hold_req;
  logic [TIME_W-1:0] cyc;

  interval_profiling_counters #(.SLOTS(SLOTS_DEF)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] sl,
                           input logic [SLOT_W-1:0] nx, input logic [TIME_W-1:0] now);
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = {now, nx, sl};
    s_tuser  = f;
    do @(posedge clk); while (!s_tready);
    sb.note_item(f, sl, nx, now);
    func_seen[f]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int                r;
    logic [SLOT_W-1:0] sl;
    logic [SLOT_W-1:0] nx;
    logic [FUNC_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_req = 1'b1;
      if (i == 2 * n / 3) drain_results();
      if ($urandom_range(0, 19) == 0) cyc = $urandom();
      else cyc = cyc + $urandom_range(0, 5000);
      sl = ($urandom_range(0, 9) != 0) ? SLOT_W'($urandom_range(0, SLOTS_DEF - 1))
                                       : SLOT_W'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r < 5) nx = sl;
      else if (r < 8) nx = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
      else nx = SLOT_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 25) f = FUNC_START;
      else if (r < 65) f = FUNC_STAMP;
      else if (r < 93) f = FUNC_QUERY;
      else f = FUNC_UNUSED;
      send_item(f, sl, nx, cyc);
    end
  endtask

  // receiver: rotating stall modes plus one long hold-off on request
  initial begin
    int          hold_left;
    int          mode;
    int          phase;
    logic [31:0] mask;
    hold_left = 0;
    mode      = 0;
    phase     = 0;
    mask      = '1;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 64 == 0) begin
        mode = $urandom_range(0, 3);
        mask = $urandom();
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = mask[5'(phase % 32)];
          default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_stats(m_tuser[0], m_tdata[SUM_W-1:0], m_tdata[SUM_W+CNT_W-1:SUM_W],
                     m_tdata[SUM_W+2*CNT_W-1:SUM_W+CNT_W]);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    cyc        = '0;
    for (int i = 0; i < 4; i++) func_seen[i] = 0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty and out-of-range slots after reset
    send_item(FUNC_QUERY, 8'd0, 8'd0, 32'd0);
    send_item(FUNC_QUERY, 8'd16, 8'd255, 32'hFFFF_FFFF);
    send_item(FUNC_QUERY, 8'd255, 8'd0, 32'd0);
    // maximum interval, back-to-back restart, then a wrapping difference
    send_item(FUNC_START, 8'd0, 8'd255, 32'd0);
    send_item(FUNC_STAMP, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(FUNC_STAMP, 8'd0, 8'd255, 32'd5);
    send_item(FUNC_QUERY, 8'd0, 8'd0, 32'd0);
    // restart of another slot, restart target out of range
    send_item(FUNC_START, 8'd15, 8'd0, 32'h8000_0000);
    send_item(FUNC_STAMP, 8'd15, 8'd1, 32'h7FFF_FFFF);
    send_item(FUNC_STAMP, 8'd1, 8'd16, 32'h8000_0010);
    // ignored items: bad slot on start and stamp, unused code
    send_item(FUNC_START, 8'd16, 8'd0, 32'd123);
    send_item(FUNC_STAMP, 8'd255, 8'd2, 32'd99);
    send_item(FUNC_UNUSED, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(FUNC_STAMP, 8'd2, 8'd2, 32'd1000);
    send_item(FUNC_STAMP, 8'd14, 8'd255, 32'hFFFF_FFFE);
    send_item(FUNC_QUERY, 8'd15, 8'd0, 32'd0);
    send_item(FUNC_QUERY, 8'd1, 8'd0, 32'd0);
    send_item(FUNC_QUERY, 8'd2, 8'd0, 32'd0);
    send_item(FUNC_QUERY, 8'd14, 8'd0, 32'd0);
    send_item(FUNC_QUERY, 8'd0, 8'd0, 32'd0);

    run_random(RANDOM_ITEMS);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_stats.size() != 0) begin
      $error("%0d query results never arrived", sb.expected_stats.size());
      sb.mismatches++;
    end

    $display("input transfers: %0d start, %0d stamp, %0d query, %0d unused code",
             func_seen[FUNC_START], func_seen[FUNC_STAMP], func_seen[FUNC_QUERY],
             func_seen[FUNC_UNUSED]);
    $display("query results checked: %0d, field mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
